### hdl/pdm_pkg.sv
// Shared constants, types and the quarter-wave sine table of the PSK demodulator.
package pdm_pkg;

  localparam int SAMPLE_W               = 16;
  localparam int SINE_TABLE_BITS        = 10;
  localparam int MAX_SAMPLES_PER_SYMBOL = 1024;
  localparam int MAX_POINTS             = 16;

  localparam int MODE_W     = 2;
  localparam int SPS_W      = 11;
  localparam int PHASE_W    = 32;
  localparam int SUM_W      = 27;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int SINE_W  = SAMPLE_W - 1;
  localparam int QTR_LEN = 1 << (SINE_TABLE_BITS - 2);
  localparam int PT_W    = $clog2(MAX_POINTS);
  localparam int NB_W    = 3;
  localparam int SYM_W   = 4;
  localparam int POINTS_W = SYM_W + 1;
  localparam int CNT_W   = $clog2(MAX_SAMPLES_PER_SYMBOL);
  localparam int CMP_W   = (CNT_W + 1 > SPS_W) ? CNT_W + 1 : SPS_W;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam logic [MODE_W-1:0]  LEVELS_MODE_RST = MODE_W'(1);
  localparam logic [SPS_W-1:0]   SPS_RST         = SPS_W'(10);
  localparam logic [PHASE_W-1:0] PHASE_STEP_RST  = PHASE_W'(429496730);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEVELS_MODE = 2'd0,
    CFG_SPS         = 2'd1,
    CFG_PHASE_STEP  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [MODE_W-1:0]  levels_mode;
    logic [SPS_W-1:0]   sps;
    logic [PHASE_W-1:0] phase_step;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic [SYM_W-1:0] sym;
    logic [NB_W-1:0]  nbits;
  } res_t;

  typedef logic [QTR_LEN:0][SINE_W-1:0] qsin_tab_t;

  // Quarter-wave sine in Q2.14 from a six-term Taylor series in Q30.
  function automatic qsin_tab_t build_qsin();
    qsin_tab_t          tab;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] acc;
    logic [63:0]        res;
    for (int r = 0; r <= QTR_LEN; r++) begin
      x    = (HALF_PI_Q30 * 64'(r)) >> (SINE_TABLE_BITS - 2);
      x2   = (x * x) >> 30;
      term = x;
      acc  = $signed(x);
      term = ((term * x2) >> 30) / 64'd6;
      acc  = acc - $signed(term);
      term = ((term * x2) >> 30) / 64'd20;
      acc  = acc + $signed(term);
      term = ((term * x2) >> 30) / 64'd42;
      acc  = acc - $signed(term);
      term = ((term * x2) >> 30) / 64'd72;
      acc  = acc + $signed(term);
      term = ((term * x2) >> 30) / 64'd110;
      acc  = acc - $signed(term);
      if (acc < 0) begin
        acc = '0;
      end
      res = ($unsigned(acc) + 64'd32768) >> 16;
      if (res > 64'd16384) begin
        res = 64'd16384;
      end
      tab[r] = res[SINE_W-1:0];
    end
    return tab;
  endfunction

  localparam qsin_tab_t QSIN_TAB = build_qsin();

endpackage

### hdl/pdm_if.sv
// Handshake interfaces for the sample, bit and configuration channels.
interface pdm_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [pdm_pkg::SAMPLE_W-1:0] sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink (input valid, input sample_value, output ready);
endinterface

interface pdm_out_if;
  logic valid;
  logic ready;
  logic data_bit;
  logic last_bit;

  modport source (output valid, output data_bit, output last_bit, input ready);
  modport sink (input valid, input data_bit, input last_bit, output ready);
endinterface

interface pdm_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [pdm_pkg::CFG_IDX_W-1:0]     index;
  logic [pdm_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/psk_min_distance_demodulator_core.sv
// Top level of the minimum-distance PSK demodulator: registers, accumulator and bit output.
//
// Samples arrive on in_i, one signed Q2.14 value per transfer. For every active
// constellation point the block adds the absolute difference between the sample
// and a table sine at that point's phase offset to a per-point sum kept in a RAM.
// One shared lookup, subtract and accumulate unit visits one point per cycle, so
// in_i.ready stays low after each transfer until all N points (N = 2, 4, 8 or 16)
// are summed, and at a decision until the result enters the output register.
// After samples_per_symbol samples the smallest sum is picked, lowest index on a
// tie, and its index leaves on out_o as log2(N) bits, MSB first, last_bit set on
// the final one. The first bit is offered once the deciding sample's result is
// loaded into the output register. The bits of a symbol sit in that register, so the next
// samples are taken while they drain; a further decision waits until the register
// empties. A stalled receiver therefore holds the block only at its next decision.
// cfg_i writes levels_mode, samples_per_symbol and phase_step by index and is
// always ready; the user must write it only while the block is idle, which the block does not enforce.
// Reset restores the register defaults and clears the sample count, the
// carrier phase and all sums at once through per-entry valid bits.
module psk_min_distance_demodulator_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  pdm_in_if.sink     in_i,
  pdm_out_if.source  out_o,
  pdm_cfg_if.sink    cfg_i
);
  import pdm_pkg::*;

  cfg_t             cfg_q;
  logic [NB_W-1:0]  out_cnt_q;
  logic [SYM_W-1:0] out_sym_q;

  logic             acc_idle;
  logic             start;
  res_t             res;
  logic             res_ready;

  assign start     = in_i.valid && acc_idle;
  assign res_ready = (out_cnt_q == '0);

  pdm_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .sample_i    (in_i.sample_value),
    .cfg_i       (cfg_q),
    .idle_o      (acc_idle),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.levels_mode <= LEVELS_MODE_RST;
      cfg_q.sps         <= SPS_RST;
      cfg_q.phase_step  <= PHASE_STEP_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_LEVELS_MODE: cfg_q.levels_mode <= cfg_i.data[MODE_W-1:0];
        CFG_SPS:         cfg_q.sps         <= cfg_i.data[SPS_W-1:0];
        CFG_PHASE_STEP:  cfg_q.phase_step  <= cfg_i.data[PHASE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_cnt_q <= '0;
    end else if (res.valid && res_ready) begin
      out_cnt_q <= res.nbits;
    end else if (out_o.valid && out_o.ready) begin
      out_cnt_q <= out_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && res_ready) begin
      out_sym_q <= res.sym << (SYM_W - int'(res.nbits));
    end else if (out_o.valid && out_o.ready) begin
      out_sym_q <= out_sym_q << 1;
    end
  end

  assign in_i.ready     = acc_idle;
  assign cfg_i.ready    = 1'b1;
  assign out_o.valid    = (out_cnt_q != '0);
  assign out_o.data_bit = out_sym_q[SYM_W-1];
  assign out_o.last_bit = (out_cnt_q == NB_W'(1));

endmodule

### hdl/pdm_sine_lut.sv
// Full-wave sine lookup built from the quarter-wave table by symmetry.
module pdm_sine_lut (
  input  logic [pdm_pkg::SINE_TABLE_BITS-1:0] idx_i,
  output logic signed [pdm_pkg::SAMPLE_W-1:0] sine_o
);
  import pdm_pkg::*;

  logic [1:0]                 quad;
  logic [SINE_TABLE_BITS-3:0] r;
  logic [SINE_TABLE_BITS-2:0] rr;
  logic [SINE_W-1:0]          mag;
  logic signed [SAMPLE_W-1:0] mag_s;

  always_comb begin
    quad = idx_i[SINE_TABLE_BITS-1 -: 2];
    r    = idx_i[SINE_TABLE_BITS-3:0];
    if (quad[0]) begin
      rr = (SINE_TABLE_BITS-1)'(QTR_LEN) - {1'b0, r};
    end else begin
      rr = {1'b0, r};
    end
    mag    = QSIN_TAB[rr];
    mag_s  = $signed({1'b0, mag});
    sine_o = quad[1] ? -mag_s : mag_s;
  end

endmodule

### hdl/pdm_accum.sv
// Distance accumulator: per-point sums in a RAM, one point per cycle, with decision.
module pdm_accum (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [pdm_pkg::SAMPLE_W-1:0] sample_i,
  input  pdm_pkg::cfg_t                       cfg_i,
  output logic                                idle_o,
  output pdm_pkg::res_t                       res_o,
  input  logic                                res_ready_i
);
  import pdm_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_HOLD} state_e;

  state_e                     st_q;
  logic [PT_W:0]              pt_q;
  logic                       wr_vld_q;
  logic [CNT_W-1:0]           count_q;
  logic [PHASE_W-1:0]         phase_q;
  logic [MAX_POINTS-1:0]      valid_q;

  logic signed [SAMPLE_W-1:0] sample_q;
  logic [PT_W-1:0]            wr_pt_q;
  logic signed [SAMPLE_W-1:0] wr_sine_q;
  logic [SUM_W-1:0]           rd_data_q;
  logic [PT_W-1:0]            best_q;
  logic [SUM_W-1:0]           best_sum_q;
  logic [SYM_W-1:0]           res_sym_q;
  logic [NB_W-1:0]            res_nbits_q;
  logic [SUM_W-1:0]           mem_q [MAX_POINTS];

  logic [NB_W-1:0]            nbits;
  logic [POINTS_W-1:0]        points;
  logic [PT_W:0]              active;
  logic                       issue;
  logic                       fin;
  logic [PT_W-1:0]            pt_idx;
  logic [SINE_TABLE_BITS-1:0] odd_pt;
  logic [SINE_TABLE_BITS-1:0] off_idx;
  logic [SINE_TABLE_BITS-1:0] lut_idx;
  logic signed [SAMPLE_W-1:0] sine;
  logic [SUM_W-1:0]           old_sum;
  logic signed [SAMPLE_W:0]   diff;
  logic [SAMPLE_W-1:0]        absd;
  logic [SUM_W:0]             sum_w;
  logic [SUM_W-1:0]           sum_sat;
  logic                       better;
  logic [CMP_W-1:0]           next_cnt;
  logic [CMP_W-1:0]           sps_eff;
  logic                       decide;

  always_comb begin
    nbits  = NB_W'(cfg_i.levels_mode) + 1'b1;
    points = POINTS_W'(1) << nbits;
    if (32'(points) > MAX_POINTS) begin
      active = (PT_W+1)'(MAX_POINTS);
    end else begin
      active = (PT_W+1)'(points);
    end
    issue  = (st_q == S_RUN) && (pt_q < active);
    fin    = (st_q == S_RUN) && !issue && !wr_vld_q;
    pt_idx = pt_q[PT_W-1:0];
    odd_pt = SINE_TABLE_BITS'({pt_idx, 1'b1});
    if (nbits == NB_W'(1)) begin
      off_idx = pt_idx[0] ? (SINE_TABLE_BITS'(1) << (SINE_TABLE_BITS - 2)) : '0;
    end else begin
      off_idx = odd_pt << (SINE_TABLE_BITS - 1 - int'(nbits));
    end
    lut_idx = phase_q[PHASE_W-1 -: SINE_TABLE_BITS] + off_idx;
  end

  pdm_sine_lut u_sine_lut (
    .idx_i  (lut_idx),
    .sine_o (sine)
  );

  always_comb begin
    old_sum = valid_q[wr_pt_q] ? rd_data_q : '0;
    diff    = $signed({wr_sine_q[SAMPLE_W-1], wr_sine_q})
            - $signed({sample_q[SAMPLE_W-1], sample_q});
    absd    = diff[SAMPLE_W] ? SAMPLE_W'(-diff) : SAMPLE_W'(diff);
    sum_w   = {1'b0, old_sum} + (SUM_W+1)'(absd);
    sum_sat = sum_w[SUM_W] ? '1 : sum_w[SUM_W-1:0];
    better  = (wr_pt_q == '0) || (sum_sat < best_sum_q);

    next_cnt = CMP_W'(count_q) + 1'b1;
    if (cfg_i.sps == '0) begin
      sps_eff = CMP_W'(1);
    end else if (CMP_W'(cfg_i.sps) > CMP_W'(MAX_SAMPLES_PER_SYMBOL)) begin
      sps_eff = CMP_W'(MAX_SAMPLES_PER_SYMBOL);
    end else begin
      sps_eff = CMP_W'(cfg_i.sps);
    end
    decide = next_cnt >= sps_eff;
  end

  always_ff @(posedge clk_i) begin
    if (wr_vld_q) begin
      mem_q[wr_pt_q] <= sum_sat;
    end
    if (issue) begin
      rd_data_q <= mem_q[pt_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && start_i) begin
      sample_q <= sample_i;
    end
    if (issue) begin
      wr_pt_q   <= pt_idx;
      wr_sine_q <= sine;
    end
    if (wr_vld_q && better) begin
      best_q     <= wr_pt_q;
      best_sum_q <= sum_sat;
    end
    if (fin && decide) begin
      res_sym_q   <= SYM_W'(best_q);
      res_nbits_q <= nbits;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      pt_q     <= '0;
      wr_vld_q <= 1'b0;
      count_q  <= '0;
      phase_q  <= '0;
      valid_q  <= '0;
    end else begin
      case (st_q)
        S_IDLE: begin
          if (start_i) begin
            pt_q <= '0;
            st_q <= S_RUN;
          end
        end
        S_RUN: begin
          wr_vld_q <= issue;
          if (issue) begin
            pt_q <= pt_q + 1'b1;
          end
          if (wr_vld_q) begin
            valid_q[wr_pt_q] <= 1'b1;
          end
          if (fin) begin
            if (decide) begin
              count_q <= '0;
              phase_q <= '0;
              valid_q <= '0;
              st_q    <= S_HOLD;
            end else begin
              count_q <= next_cnt[CNT_W-1:0];
              phase_q <= phase_q + cfg_i.phase_step;
              st_q    <= S_IDLE;
            end
          end
        end
        S_HOLD: begin
          if (res_ready_i) begin
            st_q <= S_IDLE;
          end
        end
        default: begin
          st_q <= S_IDLE;
        end
      endcase
    end
  end

  assign idle_o      = (st_q == S_IDLE);
  assign res_o.valid = (st_q == S_HOLD);
  assign res_o.sym   = res_sym_q;
  assign res_o.nbits = res_nbits_q;

  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_vld_q |-> ((PT_W+1)'(wr_pt_q) < active))
    else $error("sum write addresses an inactive point");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (st_q == S_IDLE))
    else $error("sample started while the accumulator is busy");

  a_restart_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_HOLD) |-> (valid_q == '0 && count_q == '0 && phase_q == '0))
    else $error("symbol state not restarted after a decision");

  a_decision_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin && decide) |=> res_o.valid)
    else $error("decision did not raise a result");

endmodule

### tb/tb_psk_min_distance_demodulator_core.sv
// Self-checking testbench of the PSK minimum-distance demodulator core.
`timescale 1ns / 100ps

module tb_psk_min_distance_demodulator_core;
  import pdm_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int TAIL_CYCLES  = 60;
  localparam int RAND_PHASES  = 9;
  localparam logic [SUM_W-1:0] SUM_SAT = '1;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    cfg_idx_e          reg_idx;
    logic [31:0]       wdata;
    logic signed [15:0] smp;
    logic              typed;
    logic [3:0]        sym;
  } stim_row_t;

  typedef struct packed {
    logic data_bit;
    logic last_bit;
  } bit_exp_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pdm_in_if  smp_if ();
  pdm_out_if bit_if ();
  pdm_cfg_if reg_if ();

  psk_min_distance_demodulator_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (smp_if),
    .out_o  (bit_if),
    .cfg_i  (reg_if)
  );

  stim_row_t dir_tab [0:23] = '{
    '{ROW_SAMPLE, CFG_LEVELS_MODE, 32'd0,          16'sd0,      1'b0, 4'd0},
    '{ROW_SAMPLE, CFG_LEVELS_MODE, 32'd0,          16'sd16384,  1'b0, 4'd0},
    '{ROW_SAMPLE, CFG_LEVELS_MODE, 32'd0,          -16'sd16384, 1'b0, 4'd0},
    '{ROW_WRITE,  CFG_SPS,         32'd2,          16'sd0,      1'b0, 4'd0},
    '{ROW_SAMPLE, CFG_LEVELS_MODE, 32'd0,          16'sd32767,  1'b0, 4'd0},
    '{ROW_WRITE,  CFG_LEVELS_MODE, 32'd0,          16'sd0,      1'b0, 4'd0},
    '{ROW_WRITE,  CFG_SPS,         32'd1,          16'sd0,      1'b0, 4'd0},
    '{ROW_WRITE,  CFG_PHASE_STEP,  32'd0,          16'sd0,      1'b0, 4'd0},
    '{ROW_SAMPLE, CFG_LEVELS_MODE, 32'd0,          16'sd0,      1'b1, 4'd0},
    '{ROW_SAMPLE, CFG_LEVELS_MODE, 32'd0,          16'sd16384,  1'b1, 4'd1},
    '{ROW_SAMPLE, CFG_LEVELS_MODE, 32'd0,          16'sh8000,   1'b1, 4'd0},
    '{ROW_SAMPLE, CFG_LEVELS_MODE, 32'd0,          16'sd32767,  1'b1, 4'd1},
    '{ROW_WRITE,  CFG_SPS,         32'd0,          16'sd0,      1'b0, 4'd0},
    '{ROW_SAMPLE, CFG_LEVELS_MODE, 32'd0,          -16'sd16384, 1'b1, 4'd0},
    '{ROW_WRITE,  CFG_LEVELS_MODE, 32'd3,          16'sd0,      1'b0, 4'd0},
    '{ROW_WRITE,  CFG_SPS,         32'd3,          16'sd0,      1'b0, 4'd0},
    '{ROW_WRITE,  CFG_PHASE_STEP,  32'hFFFF_FFFF,  16'sd0,      1'b0, 4'd0},
    '{ROW_SAMPLE, CFG_LEVELS_MODE, 32'd0,          16'sd12345,  1'b0, 4'd0},
    '{ROW_WRITE,  CFG_LEVELS_MODE, 32'd2,          16'sd0,      1'b0, 4'd0},
    '{ROW_SAMPLE, CFG_LEVELS_MODE, 32'd0,          -16'sd1,     1'b0, 4'd0},
    '{ROW_WRITE,  CFG_LEVELS_MODE, 32'd1,          16'sd0,      1'b0, 4'd0},
    '{ROW_SAMPLE, CFG_LEVELS_MODE, 32'd0,          16'sd21845,  1'b0, 4'd0},
    '{ROW_WRITE,  CFG_SPS,         32'd1,          16'sd0,      1'b0, 4'd0},
    '{ROW_SAMPLE, CFG_LEVELS_MODE, 32'd0,          16'sd0,      1'b1, 4'd0}
  };

  int          qtab [0:QTR_LEN];
  logic [1:0]  cur_mode;
  logic [10:0] cur_sps;
  logic [31:0] cur_step;
  int          sym_samples;
  logic [31:0] carrier;
  int unsigned pt_sums [MAX_POINTS];
  int          tx_sym;

  bit_exp_t expected_bits [$];
  int       error_count;
  int       cycle_count;
  int       burst_left;
  int       samples_sent;
  int       symbols_decided;
  int       bits_checked;
  int       reg_writes;

  always #2 clk_i = ~clk_i;

  function automatic int quarter_wave(input int r);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    longint unsigned res;
    x    = (longint'(HALF_PI_Q30) * longint'(r)) / QTR_LEN;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (int k = 1; k <= 5; k++) begin
      term = (term * x2) >> 30;
      term = term / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    res = (longint'(acc) + 32768) >> 16;
    if (res > 16384) begin
      res = 16384;
    end
    return int'(res);
  endfunction

  function automatic int carrier_sine(input logic [31:0] phase);
    logic [SINE_TABLE_BITS-1:0] idx;
    int r;
    idx = phase[31 -: SINE_TABLE_BITS];
    r   = int'(idx[SINE_TABLE_BITS-3:0]);
    case (idx[SINE_TABLE_BITS-1 -: 2])
      2'd0: return qtab[r];
      2'd1: return qtab[QTR_LEN - r];
      2'd2: return -qtab[r];
      default: return -qtab[QTR_LEN - r];
    endcase
  endfunction

  function automatic logic [31:0] point_offset(input int nb, input int p);
    if (nb == 1) begin
      return (p != 0) ? 32'h4000_0000 : 32'h0;
    end
    return 32'(2 * p + 1) << (31 - nb);
  endfunction

  function automatic void restart_symbol();
    sym_samples = 0;
    carrier     = '0;
    foreach (pt_sums[i]) begin
      pt_sums[i] = 0;
    end
  endfunction

  // Accumulates one sample into the per-point distances and decides at the symbol end.
  function automatic void absorb_sample(input logic signed [15:0] s, output bit decided,
                                        output int sym, output int nb);
    int          active;
    int          eff_sps;
    int          d;
    int unsigned acc;
    nb      = int'(cur_mode) + 1;
    active  = ((1 << nb) < MAX_POINTS) ? (1 << nb) : MAX_POINTS;
    eff_sps = int'(cur_sps);
    if (eff_sps < 1) begin
      eff_sps = 1;
    end
    if (eff_sps > MAX_SAMPLES_PER_SYMBOL) begin
      eff_sps = MAX_SAMPLES_PER_SYMBOL;
    end
    for (int p = 0; p < active; p++) begin
      d = carrier_sine(carrier + point_offset(nb, p)) - int'(s);
      if (d < 0) begin
        d = -d;
      end
      acc        = pt_sums[p] + d;
      pt_sums[p] = (acc > SUM_SAT) ? SUM_SAT : acc;
    end
    carrier     = carrier + cur_step;
    sym_samples = sym_samples + 1;
    decided     = (sym_samples >= eff_sps);
    sym         = 0;
    if (decided) begin
      for (int p = 1; p < active; p++) begin
        if (pt_sums[p] < pt_sums[sym]) begin
          sym = p;
        end
      end
      restart_symbol();
    end
  endfunction

  // Mostly a clean PSK waveform for one chosen symbol plus noise, sometimes a raw word.
  function automatic logic signed [15:0] make_sample();
    int nb;
    int v;
    nb = int'(cur_mode) + 1;
    if (sym_samples == 0 || tx_sym >= (1 << nb)) begin
      tx_sym = $urandom_range(0, (1 << nb) - 1);
    end
    if ($urandom_range(0, 4) == 0) begin
      return 16'($urandom);
    end
    v = carrier_sine(carrier + point_offset(nb, tx_sym)) +
        int'($urandom_range(0, 4000)) - 2000;
    if (v > 32767) begin
      v = 32767;
    end
    if (v < -32768) begin
      v = -32768;
    end
    return 16'(v);
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  task automatic send_sample(input logic signed [15:0] s, input logic typed,
                             input int typed_sym);
    int       gap;
    bit       decided;
    int       sym;
    int       nb;
    bit_exp_t e;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        @(negedge clk_i);
        smp_if.valid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    smp_if.valid        = 1'b1;
    smp_if.sample_value = s;
    do @(posedge clk_i); while (!smp_if.ready);
    burst_left--;
    samples_sent++;
    absorb_sample(s, decided, sym, nb);
    if (typed) begin
      if (!decided) begin
        report_mismatch("directed row expects a decision that the symbol does not reach");
      end
      sym = typed_sym;
    end
    if (decided) begin
      symbols_decided++;
      for (int b = nb - 1; b >= 0; b--) begin
        e.data_bit    = sym[b];
        e.last_bit    = (b == 0);
        expected_bits = {expected_bits, e};
      end
    end
  endtask

  // Registers change only once every expected bit is out and the block has gone quiet.
  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] val);
    @(negedge clk_i);
    smp_if.valid = 1'b0;
    while (expected_bits.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    reg_if.valid = 1'b1;
    reg_if.index = idx;
    reg_if.data  = val;
    do @(posedge clk_i); while (!reg_if.ready);
    case (idx)
      CFG_LEVELS_MODE: cur_mode = val[MODE_W-1:0];
      CFG_SPS:         cur_sps  = val[SPS_W-1:0];
      CFG_PHASE_STEP:  cur_step = val;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    reg_if.valid = 1'b0;
  endtask

  always @(negedge clk_i) begin
    if (cycle_count % 128 < 48) begin
      bit_if.ready = 1'b1;
    end else if (cycle_count % 128 < 96) begin
      bit_if.ready = ($urandom_range(0, 2) != 0);
    end else begin
      bit_if.ready = (cycle_count % 4 == 0);
    end
  end

  always @(posedge clk_i) begin
    bit_exp_t e;
    if (rst_ni && bit_if.valid && bit_if.ready) begin
      if (expected_bits.size() == 0) begin
        report_mismatch($sformatf("unexpected bit %0b last %0b", bit_if.data_bit,
                                  bit_if.last_bit));
      end else begin
        e = expected_bits.pop_front();
        bits_checked++;
        if (bit_if.data_bit !== e.data_bit) begin
          report_mismatch($sformatf("data_bit %0b, expected %0b", bit_if.data_bit,
                                    e.data_bit));
        end
        if (bit_if.last_bit !== e.last_bit) begin
          report_mismatch($sformatf("last_bit %0b, expected %0b", bit_if.last_bit,
                                    e.last_bit));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d bits outstanding", cycle_count,
               expected_bits.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int          n_items;
    logic [31:0] step_pick;
    logic [10:0] sps_pick;
    rst_ni              = 1'b0;
    smp_if.valid        = 1'b0;
    smp_if.sample_value = '0;
    reg_if.valid        = 1'b0;
    reg_if.index        = CFG_LEVELS_MODE;
    reg_if.data         = '0;
    error_count         = 0;
    burst_left          = 0;
    samples_sent        = 0;
    symbols_decided     = 0;
    reg_writes          = 0;
    tx_sym              = 0;
    for (int r = 0; r <= QTR_LEN; r++) begin
      qtab[r] = quarter_wave(r);
    end
    cur_mode = LEVELS_MODE_RST;
    cur_sps  = SPS_RST;
    cur_step = PHASE_STEP_RST;
    restart_symbol();

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_WRITE) begin
        write_reg(dir_tab[i].reg_idx, dir_tab[i].wdata);
      end else begin
        send_sample(dir_tab[i].smp, dir_tab[i].typed, int'(dir_tab[i].sym));
      end
    end

    // Two phases near the end keep one symbol open under the largest sample counts,
    // first by exact value, then clamped; the last phase shortens it so it closes.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      n_items  = 45;
      sps_pick = 11'($urandom_range(1, 12));
      case ($urandom_range(0, 4))
        0:       step_pick = 32'h0;
        1:       step_pick = 32'hFFFF_FFFF;
        2:       step_pick = $urandom;
        default: step_pick = $urandom_range(1, 32'h1000_0000);
      endcase
      if (ph == RAND_PHASES - 3) begin
        sps_pick = 11'(MAX_SAMPLES_PER_SYMBOL);
      end
      if (ph == RAND_PHASES - 2) begin
        sps_pick = '1;
      end
      write_reg(CFG_LEVELS_MODE, (ph < 4) ? 32'(ph) : 32'($urandom_range(0, 3)));
      write_reg(CFG_SPS, 32'(sps_pick));
      write_reg(CFG_PHASE_STEP, step_pick);
      repeat (n_items) send_sample(make_sample(), 1'b0, 0);
    end

    @(negedge clk_i);
    smp_if.valid = 1'b0;
    while (expected_bits.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d samples over %0d register writes, all four constellation sizes.",
             samples_sent, reg_writes);
    $display("Decided %0d symbols and checked %0d output bits, %0d mismatches.",
             symbols_decided, bits_checked, error_count);
    if (error_count == 0 && expected_bits.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
